### hdl/ffba_pkg.sv
// Shared types, constants and codes for the first-fit block allocator.
`default_nettype none

package ffba_pkg;

    localparam int DEF_MAX_ENTRIES = 64;
    localparam int DEF_PAGE_BYTES  = 4096;

    localparam int WORD_W    = 32;
    localparam int HDR_W     = 7;
    localparam int HANDLE_W  = 6;
    localparam int STATUS_W  = 3;
    localparam int ADDR_W    = 3;
    // Widest entry index and entry count over the whole parameter range.
    localparam int IDX_MAX_W = 10;
    localparam int CNT_MAX_W = 11;

    localparam logic [HDR_W-1:0]  HDR_RESET  = 7'd24;
    localparam logic [WORD_W-1:0] GRAIN_ADD  = 32'd7;
    localparam logic [WORD_W-1:0] GRAIN_MASK = 32'hFFFF_FFF8;
    // Largest request that still fits in a word after rounding up to 8 bytes.
    localparam logic [WORD_W-1:0] GRAIN_LIM  = 32'hFFFF_FFF8;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_FREE    = 2'd1,
        OP_REALLOC = 2'd2,
        OP_CALLOC  = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_NULL    = 3'd1,
        ST_NOSPACE = 3'd2,
        ST_BIG     = 3'd3,
        ST_BADH    = 3'd4
    } t_status;

    typedef enum logic {
        REG_HEADER_BYTES = 1'b0,
        REG_UNUSED       = 1'b1
    } t_reg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_MUL,
        S_RD_WAIT,
        S_GRANT,
        S_SCAN,
        S_REGION,
        S_ROUND,
        S_POST,
        S_DONE
    } t_state;

    // Broadcast from the controller to every cell of the row.
    typedef struct packed {
        logic                  fit;
        logic [WORD_W-1:0]     need;
        logic [CNT_MAX_W-1:0]  used;
        logic                  rd_en;
        logic [IDX_MAX_W-1:0]  rd_idx;
        logic                  wr_en;
        logic [IDX_MAX_W-1:0]  wr_idx;
        logic                  wr_bytes_en;
        logic [WORD_W-1:0]     wr_bytes;
        logic                  wr_free;
    } t_cell_cmd;

    // Per-cell scan outcome, one-cycle pulses.
    typedef struct packed {
        logic hit;
        logic miss;
    } t_cell_rsp;

endpackage

`default_nettype wire

### hdl/first_fit_block_allocator_core.sv
// Top level of the first-fit block allocator: controller, cell row and register port.
// Work per item: shortest for a null free or a bad handle, longer for a free, which
// first reads its entry, and longest for a calloc or a realloc that appends; the scan
// grows with entries_used, as the first-fit token walks the row one entry per cycle.
// Throughput: one item at a time; the next item is taken once the result is loaded
// into the output register, which may still be waiting to be taken.
// Reset clears the entry count, the header register to 24 and all handshake state.
`default_nettype none

module first_fit_block_allocator_core
    import ffba_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int PAGE_BYTES  = DEF_PAGE_BYTES
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Input channel.
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [1:0]           i_op,
    input  wire logic [WORD_W-1:0]    i_request_size,
    input  wire logic [WORD_W-1:0]    i_member_count,
    input  wire logic                 i_has_handle,
    input  wire logic [HANDLE_W-1:0]  i_handle_in,
    // Output channel.
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [STATUS_W-1:0]       o_status,
    output logic [HANDLE_W-1:0]       o_handle_out,
    output logic [WORD_W-1:0]         o_block_bytes,
    output logic                      o_grew_table,
    output logic                      o_moved,
    output logic [WORD_W-1:0]         o_copy_bytes,
    // Register port.
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [ADDR_W-1:0]    paddr,
    input  wire logic [WORD_W-1:0]    pwdata,
    output logic [WORD_W-1:0]         prdata,
    output logic                      pready
);

    // Width of the entry count, which must be able to hold MAX_ENTRIES itself.
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    // Page arithmetic is carried in 34 bits: a rounded request plus the header
    // and a page's worth of rounding can go past 2^32.
    localparam logic [33:0] PAGE_W    = 34'(PAGE_BYTES);
    localparam logic [33:0] PAGE_MASK = ~(PAGE_W - 34'd1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_ENTRIES);

    // ------------------------------------------------------------------
    // Register port. The user must change the header size only while the block is idle; it is not enforced.
    // ------------------------------------------------------------------
    logic [HDR_W-1:0] r_hdr;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (t_reg'(paddr[2]) == REG_HEADER_BYTES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr <= HDR_RESET;
        end else if (cfg_wr) begin
            r_hdr <= pwdata[HDR_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (t_reg'(paddr[2]) == REG_HEADER_BYTES) begin
            prdata = WORD_W'(r_hdr);
        end
    end

    // ------------------------------------------------------------------
    // Controller registers.
    // ------------------------------------------------------------------
    t_state                r_state, n_state;
    t_op                   r_op, n_op;
    logic [WORD_W-1:0]     r_size, n_size;
    logic [WORD_W-1:0]     r_count, n_count;
    logic                  r_hh, n_hh;
    logic [HANDLE_W-1:0]   r_hin, n_hin;
    logic [63:0]           r_prod, n_prod;
    logic [WORD_W-1:0]     r_need, n_need;
    logic [WORD_W-1:0]     r_round8, n_round8;
    logic [32:0]           r_region, n_region;
    logic [33:0]           r_paged, n_paged;
    logic [WORD_W-1:0]     r_old, n_old;
    logic                  r_moving, n_moving;
    logic                  r_start, n_start;
    logic [CNT_W-1:0]      r_pos, n_pos;
    logic [CNT_W-1:0]      r_used, n_used;

    // Result being built for the current item.
    t_status               r_st, n_st;
    logic [HANDLE_W-1:0]   r_h, n_h;
    logic [WORD_W-1:0]     r_bytes, n_bytes;
    logic                  r_grew, n_grew;
    logic                  r_moved, n_moved;
    logic [WORD_W-1:0]     r_copy, n_copy;

    // Output register; it parts the result from the next item's work.
    logic                  r_ov, n_ov;
    t_status               r_o_st, n_o_st;
    logic [HANDLE_W-1:0]   r_o_h, n_o_h;
    logic [WORD_W-1:0]     r_o_bytes, n_o_bytes;
    logic                  r_o_grew, n_o_grew;
    logic                  r_o_moved, n_o_moved;
    logic [WORD_W-1:0]     r_o_copy, n_o_copy;

    // ------------------------------------------------------------------
    // Row of cells. Each cell holds one entry. During a scan a single token
    // enters cell 0 and moves one cell per cycle; it stops at the first free
    // entry that is large enough (hit) or at the first unfilled cell (miss).
    // If it leaves the last cell, every entry is filled and none fits.
    // Reads and writes by index are broadcast; the selected cell answers on
    // the read bus, which every other cell holds at zero.
    // ------------------------------------------------------------------
    t_cell_cmd             cmd;
    logic [MAX_ENTRIES:0]  w_tok;
    t_cell_rsp             w_rsp [MAX_ENTRIES];
    logic [WORD_W-1:0]     w_rd  [MAX_ENTRIES];
    logic                  hit_any;
    logic                  miss_any;
    logic [WORD_W-1:0]     rd_bus;

    assign w_tok[0] = r_start;

    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        ffba_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (cmd),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1]),
            .o_rsp   (w_rsp[g]),
            .o_rd    (w_rd[g])
        );
    end

    always_comb begin
        hit_any  = 1'b0;
        miss_any = w_tok[MAX_ENTRIES];
        rd_bus   = '0;
        for (int k = 0; k < MAX_ENTRIES; k++) begin
            hit_any  = hit_any  | w_rsp[k].hit;
            miss_any = miss_any | w_rsp[k].miss;
            rd_bus   = rd_bus   | w_rd[k];
        end
    end

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    logic              hvalid;
    logic [CNT_W-1:0]  hit_pos;
    logic [WORD_W-1:0] new_bytes;

    always_comb begin
        // A handle is good only if it names an entry that has been appended.
        hvalid    = r_hh && (32'(r_hin) < 32'(r_used));
        // The hit pulse is registered, so the cell that hit saw the token in the cycle before it arrived.
        hit_pos   = r_pos - CNT_W'(1);
        new_bytes = r_paged[WORD_W-1:0] - WORD_W'(r_hdr);
    end

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_size    = r_size;
        n_count   = r_count;
        n_hh      = r_hh;
        n_hin     = r_hin;
        n_prod    = r_prod;
        n_need    = r_need;
        n_round8  = r_round8;
        n_region  = r_region;
        n_paged   = r_paged;
        n_old     = r_old;
        n_moving  = r_moving;
        n_start   = 1'b0;
        n_pos     = r_pos;
        n_used    = r_used;
        n_st      = r_st;
        n_h       = r_h;
        n_bytes   = r_bytes;
        n_grew    = r_grew;
        n_moved   = r_moved;
        n_copy    = r_copy;

        n_ov      = r_ov && i_out_stall;
        n_o_st    = r_o_st;
        n_o_h     = r_o_h;
        n_o_bytes = r_o_bytes;
        n_o_grew  = r_o_grew;
        n_o_moved = r_o_moved;
        n_o_copy  = r_o_copy;

        cmd       = '0;
        cmd.used  = CNT_MAX_W'(r_used);
        cmd.need  = r_round8;

        o_in_stall = (r_state != S_IDLE);

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op    = t_op'(i_op);
                    n_size  = i_request_size;
                    n_count = i_member_count;
                    n_hh    = i_has_handle;
                    n_hin   = i_handle_in;
                    n_state = S_DISPATCH;
                end
            end

            S_DISPATCH: begin
                n_st     = ST_NULL;
                n_h      = '0;
                n_bytes  = '0;
                n_grew   = 1'b0;
                n_moved  = 1'b0;
                n_copy   = '0;
                n_moving = 1'b0;
                n_need   = r_size;
                case (r_op)
                    OP_ALLOC: begin
                        n_state = S_GRANT;
                    end
                    OP_FREE: begin
                        if (!r_hh) begin
                            n_state = S_DONE;
                        end else if (!hvalid) begin
                            n_st    = ST_BADH;
                            n_state = S_DONE;
                        end else begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_idx = IDX_MAX_W'(r_hin);
                            n_state    = S_RD_WAIT;
                        end
                    end
                    OP_REALLOC: begin
                        if (!r_hh) begin
                            n_state = S_GRANT;
                        end else if (!hvalid) begin
                            n_st    = ST_BADH;
                            n_state = S_DONE;
                        end else if (r_size == '0) begin
                            // Shrinking to nothing releases the entry.
                            cmd.wr_en   = 1'b1;
                            cmd.wr_idx  = IDX_MAX_W'(r_hin);
                            cmd.wr_free = 1'b1;
                            n_state     = S_DONE;
                        end else begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_idx = IDX_MAX_W'(r_hin);
                            n_state    = S_RD_WAIT;
                        end
                    end
                    OP_CALLOC: begin
                        n_prod  = 64'(r_count) * 64'(r_size);
                        n_state = S_MUL;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end

            S_MUL: begin
                if (r_prod == '0) begin
                    n_state = S_DONE;
                end else if (r_prod[63:WORD_W] != '0) begin
                    n_st    = ST_BIG;
                    n_state = S_DONE;
                end else begin
                    n_need  = r_prod[WORD_W-1:0];
                    n_state = S_GRANT;
                end
            end

            S_RD_WAIT: begin
                // The entry named by the handle is on the read bus now.
                if (r_op == OP_FREE) begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_idx  = IDX_MAX_W'(r_hin);
                    cmd.wr_free = 1'b1;
                    n_st        = ST_OK;
                    n_h         = r_hin;
                    n_bytes     = rd_bus;
                    n_state     = S_DONE;
                end else if (rd_bus >= r_size) begin
                    // Large enough already: keep it, free mark untouched.
                    n_st    = ST_OK;
                    n_h     = r_hin;
                    n_bytes = rd_bus;
                    n_state = S_DONE;
                end else begin
                    n_old    = rd_bus;
                    n_moving = 1'b1;
                    n_state  = S_GRANT;
                end
            end

            S_GRANT: begin
                if (r_need == '0) begin
                    n_st    = ST_NULL;
                    n_state = S_POST;
                end else if (r_need > GRAIN_LIM) begin
                    n_st    = ST_BIG;
                    n_state = S_POST;
                end else begin
                    n_round8 = (r_need + GRAIN_ADD) & GRAIN_MASK;
                    n_start  = 1'b1;
                    n_pos    = '0;
                    n_state  = S_SCAN;
                end
            end

            S_SCAN: begin
                cmd.fit = 1'b1;
                n_pos   = r_pos + CNT_W'(1);
                if (hit_any) begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_idx  = IDX_MAX_W'(hit_pos);
                    cmd.wr_free = 1'b0;
                    n_st        = ST_OK;
                    n_h         = HANDLE_W'(hit_pos);
                    n_bytes     = rd_bus;
                    n_state     = S_POST;
                end else if (miss_any) begin
                    if (r_used == FULL_CNT) begin
                        n_st    = ST_NOSPACE;
                        n_state = S_POST;
                    end else begin
                        n_region = {1'b0, r_round8} + 33'(r_hdr);
                        n_state  = S_REGION;
                    end
                end
            end

            S_REGION: begin
                if (34'(r_region) < PAGE_W) begin
                    n_paged = PAGE_W;
                end else begin
                    n_paged = (34'(r_region) + (PAGE_W - 34'd1)) & PAGE_MASK;
                end
                n_state = S_ROUND;
            end

            S_ROUND: begin
                if (r_paged[33:WORD_W] != '0) begin
                    n_st    = ST_BIG;
                end else begin
                    cmd.wr_en       = 1'b1;
                    cmd.wr_idx      = IDX_MAX_W'(r_used);
                    cmd.wr_bytes_en = 1'b1;
                    cmd.wr_bytes    = new_bytes;
                    cmd.wr_free     = 1'b0;
                    n_used          = r_used + CNT_W'(1);
                    n_st            = ST_OK;
                    n_h             = HANDLE_W'(r_used);
                    n_bytes         = new_bytes;
                    n_grew          = 1'b1;
                end
                n_state = S_POST;
            end

            S_POST: begin
                // A realloc that found a new block releases the old one.
                if (r_moving && (r_st == ST_OK)) begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_idx  = IDX_MAX_W'(r_hin);
                    cmd.wr_free = 1'b1;
                    n_moved     = 1'b1;
                    n_copy      = r_old;
                end
                n_state = S_DONE;
            end

            S_DONE: begin
                if (!r_ov || !i_out_stall) begin
                    n_ov      = 1'b1;
                    n_o_st    = r_st;
                    n_o_h     = r_h;
                    n_o_bytes = r_bytes;
                    n_o_grew  = r_grew;
                    n_o_moved = r_moved;
                    n_o_copy  = r_copy;
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_start <= 1'b0;
            r_used  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_start <= n_start;
            r_used  <= n_used;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_size    <= n_size;
        r_count   <= n_count;
        r_hh      <= n_hh;
        r_hin     <= n_hin;
        r_prod    <= n_prod;
        r_need    <= n_need;
        r_round8  <= n_round8;
        r_region  <= n_region;
        r_paged   <= n_paged;
        r_old     <= n_old;
        r_moving  <= n_moving;
        r_pos     <= n_pos;
        r_st      <= n_st;
        r_h       <= n_h;
        r_bytes   <= n_bytes;
        r_grew    <= n_grew;
        r_moved   <= n_moved;
        r_copy    <= n_copy;
        r_o_st    <= n_o_st;
        r_o_h     <= n_o_h;
        r_o_bytes <= n_o_bytes;
        r_o_grew  <= n_o_grew;
        r_o_moved <= n_o_moved;
        r_o_copy  <= n_o_copy;
    end

    assign o_out_valid   = r_ov;
    assign o_status      = r_o_st;
    assign o_handle_out  = r_o_h;
    assign o_block_bytes = r_o_bytes;
    assign o_grew_table  = r_o_grew;
    assign o_moved       = r_o_moved;
    assign o_copy_bytes  = r_o_copy;

endmodule

`default_nettype wire

### hdl/ffba_cell.sv
// One table entry of the allocator with its slice of the first-fit scan.
`default_nettype none

module ffba_cell
    import ffba_pkg::*;
#(
    parameter int CELL_IDX = 0
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cell_cmd         i_cmd,
    input  wire logic              i_tok,
    output logic                   o_tok,
    output t_cell_rsp              o_rsp,
    output logic [WORD_W-1:0]      o_rd
);

    localparam logic [IDX_MAX_W-1:0] MY_IDX = IDX_MAX_W'(CELL_IDX);
    localparam logic [CNT_MAX_W-1:0] MY_CNT = CNT_MAX_W'(CELL_IDX);

    logic [WORD_W-1:0] r_bytes;
    logic              r_free;
    logic              r_tok;
    logic              r_hit;
    logic              r_miss;
    logic [WORD_W-1:0] r_rd;

    logic              here;
    logic              filled;
    logic              fits;
    logic              rd_sel;
    logic              wr_sel;

    always_comb begin
        here   = i_tok && i_cmd.fit;
        filled = MY_CNT < i_cmd.used;
        fits   = filled && r_free && (r_bytes >= i_cmd.need);
        rd_sel = (here && fits) || (i_cmd.rd_en && (i_cmd.rd_idx == MY_IDX));
        wr_sel = i_cmd.wr_en && (i_cmd.wr_idx == MY_IDX);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok  <= 1'b0;
            r_hit  <= 1'b0;
            r_miss <= 1'b0;
        end else begin
            // The token moves on only past a filled entry that does not fit.
            r_tok  <= here && filled && !fits;
            r_hit  <= here && fits;
            r_miss <= here && !filled;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd <= rd_sel ? r_bytes : '0;
        if (wr_sel) begin
            r_free <= i_cmd.wr_free;
            if (i_cmd.wr_bytes_en) begin
                r_bytes <= i_cmd.wr_bytes;
            end
        end
    end

    assign o_tok = r_tok;
    assign o_rsp = '{hit: r_hit, miss: r_miss};
    assign o_rd  = r_rd;

endmodule

`default_nettype wire

### hdl/ffba_checker.sv
// Port-level checks for the first-fit block allocator, bound to the top level.
`default_nettype none

module ffba_checker
    import ffba_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 o_in_stall,
    input wire logic                 o_out_valid,
    input wire logic                 i_out_stall,
    input wire logic [STATUS_W-1:0]  o_status,
    input wire logic [HANDLE_W-1:0]  o_handle_out,
    input wire logic [WORD_W-1:0]    o_block_bytes,
    input wire logic                 o_grew_table,
    input wire logic                 o_moved,
    input wire logic [WORD_W-1:0]    o_copy_bytes
);

    // A stalled word keeps its status and granted size.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
            && $stable(o_block_bytes))
        else $error("output word changed while stalled");

    // Any failed request carries no handle, size or flags.
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_OK) |-> (o_handle_out == '0)
            && (o_block_bytes == '0) && !o_grew_table && !o_moved
            && (o_copy_bytes == '0))
        else $error("failed result carries payload");

    // A moved block means the new allocation succeeded.
    a_moved_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_moved |-> (o_status == ST_OK))
        else $error("moved set on a failed realloc");

    // A new result appears only at the end of an item's work.
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without an item in progress");

endmodule

bind first_fit_block_allocator_core ffba_checker u_ffba_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_status      (o_status),
    .o_handle_out  (o_handle_out),
    .o_block_bytes (o_block_bytes),
    .o_grew_table  (o_grew_table),
    .o_moved       (o_moved),
    .o_copy_bytes  (o_copy_bytes)
);

`default_nettype wire
